/* rtl/dtq_pkg.sv */
// Shared types and constants of the deadline timer queue.
package dtq_pkg;

  // Most expiry results one tick request may produce.
  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResCntW    = $clog2(MaxResults);

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACCEPT    = 2'd0,
    KIND_EXPIRED   = 2'd1,
    KIND_IDLE_TICK = 2'd2,
    KIND_FULL      = 2'd3
  } kind_e;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_TICK   = 4'b0010,
    ST_CANCEL = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic pop;
    logic cancel;
  } cell_cmd_t;

endpackage

/* rtl/dtq_cell.sv */
// One cell of the sorted timer chain: holds a single deadline and id.
module dtq_cell
  import dtq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned ID_BITS   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_cmd_t            cmd_i,
  input  logic [TIME_BITS-1:0] new_dl_i,
  input  logic [ID_BITS-1:0]   new_id_i,
  input  logic [TIME_BITS-1:0] cur_time_i,
  // Neighbour on the head side.
  input  logic                 left_valid_i,
  input  logic [TIME_BITS-1:0] left_dl_i,
  input  logic [ID_BITS-1:0]   left_id_i,
  input  logic                 seen_i,
  input  logic                 mseen_i,
  // Neighbour on the tail side.
  input  logic                 right_valid_i,
  input  logic [TIME_BITS-1:0] right_dl_i,
  input  logic [ID_BITS-1:0]   right_id_i,
  // Own contents and chain flags.
  output logic                 valid_o,
  output logic [TIME_BITS-1:0] dl_o,
  output logic [ID_BITS-1:0]   id_o,
  output logic                 seen_o,
  output logic                 mseen_o,
  output logic                 expired_o
);

  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic                 hit;
  logic                 match;

  // Wrap-safe ordering: a is strictly before b.
  function automatic logic earlier(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] diff;
    diff = a - b;
    return diff[TIME_BITS-1];
  endfunction

  // The new timer belongs at the first cell that is empty or due later.
  assign hit    = !valid_q || earlier(new_dl_i, dl_q);
  assign seen_o = seen_i || hit;

  // The first cell holding the cancelled id, and all behind it, move up.
  assign match   = valid_q && (id_q == new_id_i);
  assign mseen_o = mseen_i || match;

  assign expired_o = valid_q && !earlier(cur_time_i, dl_q);

  // Next contents.
  always_comb begin
    valid_d = valid_q;
    dl_d    = dl_q;
    id_d    = id_q;
    if (cmd_i.insert) begin
      if (seen_i) begin
        valid_d = left_valid_i;
        dl_d    = left_dl_i;
        id_d    = left_id_i;
      end else if (hit) begin
        valid_d = 1'b1;
        dl_d    = new_dl_i;
        id_d    = new_id_i;
      end
    end else if (cmd_i.pop || (cmd_i.cancel && mseen_o)) begin
      valid_d = right_valid_i;
      dl_d    = right_dl_i;
      id_d    = right_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q <= dl_d;
    id_q <= id_d;
  end

  assign valid_o = valid_q;
  assign dl_o    = dl_q;
  assign id_o    = id_q;

endmodule

/* rtl/deadline_timer_queue_top.sv */
// Top level of the deadline timer queue: sequencer, time counter and cell chain.
//
// Usage: a request is taken at a rising edge with start high and busy low. The
// request carries an opcode (tick, start or stop), a timer id, a delay and a
// replace flag. Results leave on kind_o, fired_id_o, next_deadline_o,
// queue_empty_o and last_o, each valid for exactly one cycle while strobe_o is
// high; last_o marks the final result of a request. The receiver cannot stall.
// A tick advances the time counter and reports one result per expired timer,
// up to MaxResults, or a single idle-tick result when none is due. A stop,
// or a start with the replace flag, first removes every entry with its id;
// a start then inserts the new timer, or is refused when every cell is taken.
// Every request but a tick gives a single result. The chain of cells moves
// every entry at most one place per cycle, so removals and expiries go one at
// a time. A new request may be taken while the final result of the previous
// one is still on the outputs.
// Reset clears the time counter, empties the queue and returns to idle.
module deadline_timer_queue_top
  import dtq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  timer_id_i,
  input  logic [15:0] delay_i,
  input  logic        replace_previous_i,
  output logic        strobe_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  fired_id_o,
  output logic [31:0] next_deadline_o,
  output logic        queue_empty_o,
  output logic        last_o
);

  localparam int unsigned IdInW = (ID_BITS < 8) ? ID_BITS : 8;
  localparam int unsigned IdOutW = (ID_BITS < 8) ? ID_BITS : 8;
  localparam int unsigned NdW   = (TIME_BITS < 32) ? TIME_BITS : 32;

  state_e               state_q, state_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [TIME_BITS-1:0] new_dl_q, new_dl_d;
  logic [ID_BITS-1:0]   new_id_q, new_id_d;
  logic                 is_start_q, is_start_d;
  kind_e                fin_kind_q, fin_kind_d;
  logic [ResCntW-1:0]   res_cnt_q, res_cnt_d;
  cell_cmd_t            cmd;
  logic                 accept;

  // Result register.
  logic                 strobe_q, strobe_d;
  kind_e                kind_q, kind_d;
  logic [ID_BITS-1:0]   fired_q, fired_d;
  logic [TIME_BITS-1:0] nd_q, nd_d;
  logic                 empty_q, empty_d;
  logic                 last_q, last_d;

  // Chain wiring, index i is the link into cell i.
  logic                 cv  [DEPTH+2];
  logic [TIME_BITS-1:0] cdl [DEPTH+2];
  logic [ID_BITS-1:0]   cid [DEPTH+2];
  logic                 seen  [DEPTH+1];
  logic                 mseen [DEPTH+1];
  logic                 expired [DEPTH];
  logic [DEPTH-1:0]     valid_vec;

  assign accept = start && !busy;

  // Boundary links: nothing before the head, an empty slot after the tail.
  assign cv[0]        = 1'b0;
  assign cdl[0]       = '0;
  assign cid[0]       = '0;
  assign cv[DEPTH+1]  = 1'b0;
  assign cdl[DEPTH+1] = '0;
  assign cid[DEPTH+1] = '0;
  assign seen[0]      = 1'b0;
  assign mseen[0]     = 1'b0;

  // Cell chain, cell i sits at link i+1.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dtq_cell #(
      .TIME_BITS(TIME_BITS),
      .ID_BITS  (ID_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_dl_i     (new_dl_q),
      .new_id_i     (new_id_q),
      .cur_time_i   (time_q),
      .left_valid_i (cv[i]),
      .left_dl_i    (cdl[i]),
      .left_id_i    (cid[i]),
      .seen_i       (seen[i]),
      .mseen_i      (mseen[i]),
      .right_valid_i(cv[i+2]),
      .right_dl_i   (cdl[i+2]),
      .right_id_i   (cid[i+2]),
      .valid_o      (cv[i+1]),
      .dl_o         (cdl[i+1]),
      .id_o         (cid[i+1]),
      .seen_o       (seen[i+1]),
      .mseen_o      (mseen[i+1]),
      .expired_o    (expired[i])
    );
    assign valid_vec[i] = cv[i+1];
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    time_d     = time_q;
    new_dl_d   = new_dl_q;
    new_id_d   = new_id_q;
    is_start_d = is_start_q;
    fin_kind_d = fin_kind_q;
    res_cnt_d  = res_cnt_q;
    cmd        = '0;
    strobe_d   = 1'b0;
    kind_d     = kind_q;
    fired_d    = fired_q;
    nd_d       = nd_q;
    empty_d    = empty_q;
    last_d     = last_q;
    new_id_d   = new_id_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          new_dl_d = time_q + TIME_BITS'(delay_i);
          new_id_d = '0;
          new_id_d[IdInW-1:0] = timer_id_i[IdInW-1:0];
          is_start_d = (opcode_i == OP_START);
          fin_kind_d = KIND_ACCEPT;
          res_cnt_d  = '0;
          case (opcode_i)
            OP_TICK: begin
              time_d  = time_q + TIME_BITS'(1);
              state_d = ST_TICK;
            end
            OP_START: begin
              state_d = replace_previous_i ? ST_CANCEL : ST_FINISH;
            end
            OP_STOP: begin
              state_d = ST_CANCEL;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_TICK: begin
        strobe_d = 1'b1;
        if (expired[0]) begin
          // Pop the head and report it; the new head comes from cell one.
          cmd.pop  = 1'b1;
          kind_d   = KIND_EXPIRED;
          fired_d  = cid[1];
          nd_d     = cdl[2];
          empty_d  = !cv[2];
          last_d   = (res_cnt_q == ResCntW'(MaxResults - 1)) ||
                     (DEPTH < 2) || !expired[1 % DEPTH] || !cv[2];
          res_cnt_d = res_cnt_q + ResCntW'(1);
        end else begin
          kind_d  = KIND_IDLE_TICK;
          fired_d = '0;
          nd_d    = cdl[1];
          empty_d = !cv[1];
          last_d  = 1'b1;
        end
        if (last_d) begin
          state_d = ST_IDLE;
        end
      end
      ST_CANCEL: begin
        // Remove the first matching entry each cycle until none is left.
        if (mseen[DEPTH]) begin
          cmd.cancel = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // A start inserts here, or is refused when every cell is taken.
        if (is_start_q) begin
          if (cv[DEPTH]) begin
            fin_kind_d = KIND_FULL;
          end else begin
            cmd.insert = 1'b1;
          end
          is_start_d = 1'b0;
        end else begin
          strobe_d = 1'b1;
          kind_d   = fin_kind_q;
          fired_d  = '0;
          nd_d     = cdl[1];
          empty_d  = !cv[1];
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      time_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      time_q   <= time_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_dl_q   <= new_dl_d;
    new_id_q   <= new_id_d;
    is_start_q <= is_start_d;
    fin_kind_q <= fin_kind_d;
    res_cnt_q  <= res_cnt_d;
    kind_q     <= kind_d;
    fired_q    <= fired_d;
    nd_q       <= nd_d;
    empty_q    <= empty_d;
    last_q     <= last_d;
  end

  // Result ports, widths fitted to the fixed output fields.
  always_comb begin
    fired_id_o = '0;
    fired_id_o[IdOutW-1:0] = fired_q[IdOutW-1:0];
    next_deadline_o = '1;
    if (!empty_q) begin
      next_deadline_o = '0;
      next_deadline_o[NdW-1:0] = nd_q[NdW-1:0];
    end
  end

  assign strobe_o      = strobe_q;
  assign kind_o        = kind_q;
  assign queue_empty_o = empty_q;
  assign last_o        = last_q;

  // Occupied cells always form an unbroken run from the head.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec & (valid_vec + DEPTH'(1))) == '0))
    else $error("Gap in the occupied cells of the timer chain.");

  // A result that is not the last is followed at once by another.
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("Result burst broken before its last result.");

  // Only expiries come in bursts of more than one result.
  a_burst_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> kind_o == KIND_EXPIRED)
    else $error("Non-final result that is not an expiry.");

  // An empty queue reports the all-ones deadline.
  a_empty_deadline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && queue_empty_o |-> next_deadline_o == '1)
    else $error("Empty queue reported with a deadline.");

endmodule
